// ===== rtl/core/thjc_pkg.sv =====
`default_nettype none

package thjc_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOMING_TIMEOUT = 1'b1;
    localparam int unsigned CFG_DATA_W = 32;

    // Register reset values
    localparam logic [6:0]  DEADZONE_RESET = 7'd20;
    localparam logic [31:0] HOMING_TIMEOUT_RESET = 32'd30000;

    // Homing sequencer phase, as shown on homing_phase
    typedef enum logic [1:0] {
        PH_IDLE          = 2'd0,
        PH_SEARCH_EDGE   = 2'd1,
        PH_SEARCH_CENTRE = 2'd2,
        PH_COMPLETE      = 2'd3
    } phase_t;

    // One control tick
    typedef struct packed {
        logic [31:0]       now_ms;
        logic              pan_left_limit;
        logic              pan_right_limit;
        logic              pan_center_switch;
        logic              tilt_up_limit;
        logic              tilt_down_limit;
        logic signed [7:0] pan_stick;
        logic signed [7:0] tilt_stick;
        logic              home_button;
        logic              toggle_button;
    } tick_t;

    // Result of one tick
    typedef struct packed {
        logic               pan_step;
        logic               pan_direction;
        logic               tilt_step;
        logic               tilt_direction;
        logic               toggled_output;
        logic               is_homed;
        phase_t             homing_phase;
        logic               timed_out;
        logic signed [31:0] pan_position;
        logic signed [31:0] tilt_position;
    } result_t;

    // Controller state carried from tick to tick
    typedef struct packed {
        phase_t      phase;
        logic        homed;
        logic [31:0] homing_start_ms;
        logic        pan_dir;
        logic        tilt_dir;
        logic [31:0] pan_count;
        logic [31:0] tilt_count;
        logic        prev_home;
        logic        prev_toggle;
        logic        toggle_level;
    } ctrl_state_t;

    // Configuration registers
    typedef struct packed {
        logic [6:0]  deadzone;
        logic [31:0] homing_timeout_ms;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/thjc_step.sv =====
`default_nettype none

// Next-state and result logic for one tick
module thjc_step (
    input  wire thjc_pkg::ctrl_state_t cur,
    input  wire thjc_pkg::tick_t       tick,
    input  wire thjc_pkg::cfg_t        cfg,
    output thjc_pkg::ctrl_state_t      nxt,
    output thjc_pkg::result_t          res
);
    import thjc_pkg::*;

    logic              pstep;
    logic              tstep;
    logic              tout;
    logic [31:0]       elapsed;
    logic signed [8:0] dz9;
    logic signed [8:0] pstick9;
    logic signed [8:0] tstick9;
    logic              p_neg;
    logic              p_pos;
    logic              t_neg;
    logic              t_pos;

    // Stick against deadzone, widened so that -deadzone and 127 both fit
    assign dz9     = $signed({2'b00, cfg.deadzone});
    assign pstick9 = $signed({tick.pan_stick[7], tick.pan_stick});
    assign tstick9 = $signed({tick.tilt_stick[7], tick.tilt_stick});
    assign p_neg   = pstick9 < -dz9;
    assign p_pos   = pstick9 > dz9;
    assign t_neg   = tstick9 < -dz9;
    assign t_pos   = tstick9 > dz9;

    always_comb
    begin
        nxt   = cur;
        pstep = 1'b0;
        tstep = 1'b0;
        tout  = 1'b0;

        // Home request on a rising edge, only when the sequencer is idle
        if (tick.home_button && !cur.prev_home && cur.phase == PH_IDLE)
        begin
            nxt.homed           = 1'b0;
            nxt.pan_dir         = 1'b1;
            nxt.phase           = PH_SEARCH_EDGE;
            nxt.homing_start_ms = tick.now_ms;
        end
        nxt.prev_home = tick.home_button;

        // Sequencer step; edge switch A wins when both are closed
        case (nxt.phase)
            PH_SEARCH_EDGE:
            begin
                if (tick.pan_left_limit)
                begin
                    nxt.pan_dir = 1'b0;
                    nxt.phase   = PH_SEARCH_CENTRE;
                end
                else if (tick.pan_right_limit)
                begin
                    nxt.pan_dir = 1'b1;
                    nxt.phase   = PH_SEARCH_CENTRE;
                end
                else
                begin
                    pstep = 1'b1;
                end
            end
            PH_SEARCH_CENTRE:
            begin
                if (tick.pan_center_switch)
                begin
                    nxt.pan_count = 32'd0;
                    nxt.homed     = 1'b1;
                    nxt.phase     = PH_COMPLETE;
                end
                else
                begin
                    pstep = 1'b1;
                end
            end
            PH_COMPLETE:
            begin
                nxt.phase = PH_IDLE;
            end
            default:
            begin
            end
        endcase

        // Abort a search that has run too long (elapsed time wraps)
        elapsed = tick.now_ms - nxt.homing_start_ms;
        if ((nxt.phase == PH_SEARCH_EDGE || nxt.phase == PH_SEARCH_CENTRE) &&
            elapsed > cfg.homing_timeout_ms)
        begin
            nxt.phase = PH_IDLE;
            nxt.homed = 1'b0;
            tout      = 1'b1;
        end

        // Jogging and toggle, only homed and idle
        if (nxt.homed && nxt.phase == PH_IDLE)
        begin
            if (p_neg && !tick.pan_left_limit)
            begin
                nxt.pan_dir   = 1'b1;
                pstep         = 1'b1;
                nxt.pan_count = nxt.pan_count - 32'd1;
            end
            else if (p_pos && !tick.pan_right_limit)
            begin
                nxt.pan_dir   = 1'b0;
                pstep         = 1'b1;
                nxt.pan_count = nxt.pan_count + 32'd1;
            end
            if (t_neg && !tick.tilt_up_limit)
            begin
                nxt.tilt_dir   = 1'b0;
                tstep          = 1'b1;
                nxt.tilt_count = nxt.tilt_count - 32'd1;
            end
            else if (t_pos && !tick.tilt_down_limit)
            begin
                nxt.tilt_dir   = 1'b1;
                tstep          = 1'b1;
                nxt.tilt_count = nxt.tilt_count + 32'd1;
            end
            if (!tick.toggle_button && cur.prev_toggle)
            begin
                nxt.toggle_level = ~cur.toggle_level;
            end
        end
        nxt.prev_toggle = tick.toggle_button;

        // Result as the state stands after the tick
        res.pan_step       = pstep;
        res.pan_direction  = nxt.pan_dir;
        res.tilt_step      = tstep;
        res.tilt_direction = nxt.tilt_dir;
        res.toggled_output = nxt.toggle_level;
        res.is_homed       = nxt.homed;
        res.homing_phase   = nxt.phase;
        res.timed_out      = tout;
        res.pan_position   = $signed(nxt.pan_count);
        res.tilt_position  = $signed(nxt.tilt_count);
    end

endmodule

`default_nettype wire

// ===== rtl/core/two_axis_homing_and_jog_controller.sv =====
// An item taken into the input register moves into the result register, raising out_valid,
// once that register is free or being taken.
// Throughput: one item per cycle; in_ready is high while the input register is empty or
// its item moves on, so items follow back to back while results are taken.
// Reset (rst_n low, asynchronous): sequencer idle, not homed, positions zero,
// deadzone 20, homing timeout 30000 ms, both stages empty.
`default_nettype none

module two_axis_homing_and_jog_controller (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // configuration
    input  wire                                 cfg_we,
    input  wire  [thjc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [thjc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input items
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [31:0]                         now_ms,
    input  wire                                 pan_left_limit,
    input  wire                                 pan_right_limit,
    input  wire                                 pan_center_switch,
    input  wire                                 tilt_up_limit,
    input  wire                                 tilt_down_limit,
    input  wire  signed [7:0]                   pan_stick,
    input  wire  signed [7:0]                   tilt_stick,
    input  wire                                 home_button,
    input  wire                                 toggle_button,
    // result items
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                pan_step,
    output logic                                pan_direction,
    output logic                                tilt_step,
    output logic                                tilt_direction,
    output logic                                toggled_output,
    output logic                                is_homed,
    output logic [1:0]                          homing_phase,
    output logic                                timed_out,
    output logic signed [31:0]                  pan_position,
    output logic signed [31:0]                  tilt_position
);
    import thjc_pkg::*;

    cfg_t        cfg_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    tick_t       tick_reg;
    logic        tick_valid_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        out_valid_reg;
    logic        advance;

    // Tick moves into the result register when that register is free or being taken
    assign advance  = tick_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !tick_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadzone          <= DEADZONE_RESET;
            cfg_reg.homing_timeout_ms <= HOMING_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEADZONE:       cfg_reg.deadzone          <= cfg_data[6:0];
                CFG_HOMING_TIMEOUT: cfg_reg.homing_timeout_ms <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            tick_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg.now_ms            <= now_ms;
            tick_reg.pan_left_limit    <= pan_left_limit;
            tick_reg.pan_right_limit   <= pan_right_limit;
            tick_reg.pan_center_switch <= pan_center_switch;
            tick_reg.tilt_up_limit     <= tilt_up_limit;
            tick_reg.tilt_down_limit   <= tilt_down_limit;
            tick_reg.pan_stick         <= pan_stick;
            tick_reg.tilt_stick        <= tilt_stick;
            tick_reg.home_button       <= home_button;
            tick_reg.toggle_button     <= toggle_button;
        end
    end

    // Per-tick logic
    thjc_step u_step (
        .cur  (state_reg),
        .tick (tick_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Controller state, updated once per tick as it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= PH_IDLE;
            state_reg.homed           <= 1'b0;
            state_reg.homing_start_ms <= 32'd0;
            state_reg.pan_dir         <= 1'b0;
            state_reg.tilt_dir        <= 1'b0;
            state_reg.pan_count       <= 32'd0;
            state_reg.tilt_count      <= 32'd0;
            state_reg.prev_home       <= 1'b0;
            state_reg.prev_toggle     <= 1'b0;
            state_reg.toggle_level    <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pan_step       = res_reg.pan_step;
    assign pan_direction  = res_reg.pan_direction;
    assign tilt_step      = res_reg.tilt_step;
    assign tilt_direction = res_reg.tilt_direction;
    assign toggled_output = res_reg.toggled_output;
    assign is_homed       = res_reg.is_homed;
    assign homing_phase   = res_reg.homing_phase;
    assign timed_out      = res_reg.timed_out;
    assign pan_position   = res_reg.pan_position;
    assign tilt_position  = res_reg.tilt_position;

endmodule

`default_nettype wire

// ===== rtl/core/thjc_checker.sv =====
`default_nettype none

// Port-level checks on the controller
module thjc_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                out_valid,
    input wire                out_ready,
    input wire                pan_step,
    input wire                tilt_step,
    input wire                is_homed,
    input wire  [1:0]         homing_phase,
    input wire                timed_out,
    input wire  signed [31:0] pan_position
);
    import thjc_pkg::*;

    // An aborted search leaves the block idle and not homed
    a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timed_out) |-> (!is_homed && homing_phase == PH_IDLE))
        else $error("timeout item not idle and unhomed");

    // Homing completes with the pan axis at zero and the homed flag set
    a_complete_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && homing_phase == PH_COMPLETE) |-> (is_homed && pan_position == 32'sd0))
        else $error("homing complete without zeroed pan position");

    // Idle and not homed: no axis moves, except a step issued on an aborting tick
    a_no_jog_unhomed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_homed && !timed_out && homing_phase == PH_IDLE)
            |-> (!pan_step && !tilt_step))
        else $error("axis stepped while unhomed and idle");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pan_position)
            && $stable(homing_phase)))
        else $error("stalled result changed");

endmodule

bind two_axis_homing_and_jog_controller thjc_checker u_thjc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pan_step     (pan_step),
    .tilt_step    (tilt_step),
    .is_homed     (is_homed),
    .homing_phase (homing_phase),
    .timed_out    (timed_out),
    .pan_position (pan_position)
);

`default_nettype wire

// ===== dv/thjc_tick_checker.sv =====
`default_nettype none

module thjc_tick_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [thjc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [thjc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                 in_valid,
    input  wire                                 in_ready,
    input  wire  [31:0]                         now_ms,
    input  wire                                 pan_left_limit,
    input  wire                                 pan_right_limit,
    input  wire                                 pan_center_switch,
    input  wire                                 tilt_up_limit,
    input  wire                                 tilt_down_limit,
    input  wire  signed [7:0]                   pan_stick,
    input  wire  signed [7:0]                   tilt_stick,
    input  wire                                 home_button,
    input  wire                                 toggle_button,
    input  wire                                 out_valid,
    input  wire                                 out_ready,
    input  wire                                 pan_step,
    input  wire                                 pan_direction,
    input  wire                                 tilt_step,
    input  wire                                 tilt_direction,
    input  wire                                 toggled_output,
    input  wire                                 is_homed,
    input  wire  [1:0]                          homing_phase,
    input  wire                                 timed_out,
    input  wire  signed [31:0]                  pan_position,
    input  wire  signed [31:0]                  tilt_position,
    output int                                  mismatches,
    output int                                  results_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    import thjc_pkg::*;

    // Shadow copy of the controller and its registers
    ctrl_state_t ctl;
    cfg_t        regs;
    result_t     due_results[$];

    // One control tick of the controller; updates the shadow state
    function automatic result_t advance_controller(input tick_t t);
        result_t     r;
        logic [31:0] elapsed;
        int          ps;
        int          ts;
        int          dz;
        r  = '0;
        ps = $signed(t.pan_stick);
        ts = $signed(t.tilt_stick);
        dz = int'(regs.deadzone);

        // home press only counts when the sequencer is idle
        if (t.home_button && !ctl.prev_home && ctl.phase == PH_IDLE) begin
            ctl.homed           = 1'b0;
            ctl.pan_dir         = 1'b1;
            ctl.phase           = PH_SEARCH_EDGE;
            ctl.homing_start_ms = t.now_ms;
        end
        ctl.prev_home = t.home_button;

        // sequencer step; search steps leave the pan count alone
        case (ctl.phase)
            PH_SEARCH_EDGE:
            begin
                if (t.pan_left_limit) begin
                    ctl.pan_dir = 1'b0;
                    ctl.phase   = PH_SEARCH_CENTRE;
                end else if (t.pan_right_limit) begin
                    ctl.pan_dir = 1'b1;
                    ctl.phase   = PH_SEARCH_CENTRE;
                end else begin
                    r.pan_step = 1'b1;
                end
            end
            PH_SEARCH_CENTRE:
            begin
                if (t.pan_center_switch) begin
                    ctl.pan_count = '0;
                    ctl.homed     = 1'b1;
                    ctl.phase     = PH_COMPLETE;
                end else begin
                    r.pan_step = 1'b1;
                end
            end
            PH_COMPLETE: ctl.phase = PH_IDLE;
            default: ;
        endcase

        // abort on timeout, elapsed time taken modulo 2^32
        elapsed = t.now_ms - ctl.homing_start_ms;
        if ((ctl.phase == PH_SEARCH_EDGE || ctl.phase == PH_SEARCH_CENTRE) &&
            elapsed > regs.homing_timeout_ms) begin
            ctl.phase   = PH_IDLE;
            ctl.homed   = 1'b0;
            r.timed_out = 1'b1;
        end

        // jogging and toggle, only when homed and idle
        if (ctl.homed && ctl.phase == PH_IDLE) begin
            if (ps < -dz && !t.pan_left_limit) begin
                ctl.pan_dir   = 1'b1;
                r.pan_step    = 1'b1;
                ctl.pan_count = ctl.pan_count - 32'd1;
            end else if (ps > dz && !t.pan_right_limit) begin
                ctl.pan_dir   = 1'b0;
                r.pan_step    = 1'b1;
                ctl.pan_count = ctl.pan_count + 32'd1;
            end
            if (ts < -dz && !t.tilt_up_limit) begin
                ctl.tilt_dir   = 1'b0;
                r.tilt_step    = 1'b1;
                ctl.tilt_count = ctl.tilt_count - 32'd1;
            end else if (ts > dz && !t.tilt_down_limit) begin
                ctl.tilt_dir   = 1'b1;
                r.tilt_step    = 1'b1;
                ctl.tilt_count = ctl.tilt_count + 32'd1;
            end
            if (!t.toggle_button && ctl.prev_toggle)
                ctl.toggle_level = ~ctl.toggle_level;
        end
        ctl.prev_toggle = t.toggle_button;

        r.pan_direction  = ctl.pan_dir;
        r.tilt_direction = ctl.tilt_dir;
        r.toggled_output = ctl.toggle_level;
        r.is_homed       = ctl.homed;
        r.homing_phase   = ctl.phase;
        r.pan_position   = $signed(ctl.pan_count);
        r.tilt_position  = $signed(ctl.tilt_count);
        return r;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf({"pan step %b dir %b pos %0d, tilt step %b dir %b pos %0d, ",
                          "toggle %b homed %b phase %0d timeout %b"},
                         r.pan_step, r.pan_direction, r.pan_position,
                         r.tilt_step, r.tilt_direction, r.tilt_position,
                         r.toggled_output, r.is_homed, r.homing_phase, r.timed_out);
    endfunction

    // Watch both channels and the register port at each rising edge
    always @(posedge clk or negedge rst_n) begin : watch
        tick_t   t;
        result_t got;
        result_t exp_r;
        if (!rst_n) begin
            ctl                    = '0;
            ctl.phase              = PH_IDLE;
            regs.deadzone          = DEADZONE_RESET;
            regs.homing_timeout_ms = HOMING_TIMEOUT_RESET;
            due_results.delete();
            mismatches             = 0;
            results_owed           = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DEADZONE:       regs.deadzone = cfg_data[6:0];
                    CFG_HOMING_TIMEOUT: regs.homing_timeout_ms = cfg_data;
                    default: ;
                endcase
            end

            // result item: compare with the oldest expectation
            if (out_valid && out_ready) begin
                got.pan_step       = pan_step;
                got.pan_direction  = pan_direction;
                got.tilt_step      = tilt_step;
                got.tilt_direction = tilt_direction;
                got.toggled_output = toggled_output;
                got.is_homed       = is_homed;
                got.homing_phase   = phase_t'(homing_phase);
                got.timed_out      = timed_out;
                got.pan_position   = pan_position;
                got.tilt_position  = tilt_position;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with none expected: %s", $time, show(got));
                end else begin
                    exp_r = due_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $time, show(exp_r), show(got));
                    end
                end
            end

            // input item: predict its result
            if (in_valid && in_ready) begin
                t.now_ms            = now_ms;
                t.pan_left_limit    = pan_left_limit;
                t.pan_right_limit   = pan_right_limit;
                t.pan_center_switch = pan_center_switch;
                t.tilt_up_limit     = tilt_up_limit;
                t.tilt_down_limit   = tilt_down_limit;
                t.pan_stick         = pan_stick;
                t.tilt_stick        = tilt_stick;
                t.home_button       = home_button;
                t.toggle_button     = toggle_button;
                due_results.push_back(advance_controller(t));
            end
            results_owed = due_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_two_axis_homing_and_jog_controller.sv =====
`default_nettype none

module tb_two_axis_homing_and_jog_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import thjc_pkg::*;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [31:0]                 now_ms;
    logic                        pan_left_limit;
    logic                        pan_right_limit;
    logic                        pan_center_switch;
    logic                        tilt_up_limit;
    logic                        tilt_down_limit;
    logic signed [7:0]           pan_stick;
    logic signed [7:0]           tilt_stick;
    logic                        home_button;
    logic                        toggle_button;
    logic                        out_valid;
    logic                        out_ready;
    logic                        pan_step;
    logic                        pan_direction;
    logic                        tilt_step;
    logic                        tilt_direction;
    logic                        toggled_output;
    logic                        is_homed;
    logic [1:0]                  homing_phase;
    logic                        timed_out;
    logic signed [31:0]          pan_position;
    logic signed [31:0]          tilt_position;
    int                          mismatches;
    int                          results_owed;

    // Stimulus knobs
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          stall_burst   = 0;
    int          sent_items    = 0;
    logic [31:0] clock_ms      = 32'd0;
    logic        tog_level     = 1'b0;
    int          cur_deadzone  = 20;
    logic [31:0] cur_timeout   = 32'd30000;

    two_axis_homing_and_jog_controller dut (.*);

    thjc_tick_checker tick_check (.*);

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off when one is requested
    initial begin : sink
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_burst > 0) begin
                out_ready = 1'b0;
                stall_burst--;
            end else begin
                out_ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offer one item, with a random gap first; entered and left at a falling edge
    task automatic send_tick(input tick_t t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid          = 1'b1;
        now_ms            = t.now_ms;
        pan_left_limit    = t.pan_left_limit;
        pan_right_limit   = t.pan_right_limit;
        pan_center_switch = t.pan_center_switch;
        tilt_up_limit     = t.tilt_up_limit;
        tilt_down_limit   = t.tilt_down_limit;
        pan_stick         = t.pan_stick;
        tilt_stick        = t.tilt_stick;
        home_button       = t.home_button;
        toggle_button     = t.toggle_button;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent_items++;
    endtask

    // Switch vector order: pan A, pan B, centre, tilt A, tilt B
    task automatic direct(input logic [31:0] ms, input logic [4:0] sw,
                          input logic [7:0] ps, input logic [7:0] ts,
                          input logic home, input logic tog);
        tick_t t;
        t.now_ms = ms;
        {t.pan_left_limit, t.pan_right_limit, t.pan_center_switch,
         t.tilt_up_limit, t.tilt_down_limit} = sw;
        t.pan_stick     = ps;
        t.tilt_stick    = ts;
        t.home_button   = home;
        t.toggle_button = tog;
        send_tick(t);
    endtask

    // Stick values biased to the extremes and the deadzone boundary
    function automatic logic [7:0] pick_stick();
        int v;
        case ($urandom_range(0, 6))
            0: v = -128;
            1: v = 127;
            2: v = cur_deadzone;
            3: v = -cur_deadzone;
            4: v = cur_deadzone + 1;
            5: v = -(cur_deadzone + 1);
            default: v = int'($urandom_range(0, 255));
        endcase
        return v[7:0];
    endfunction

    function automatic logic [4:0] rand_switches(input int pct);
        logic [4:0] sw;
        for (int i = 0; i < 5; i++)
            sw[i] = ($urandom_range(0, 99) < pct);
        return sw;
    endfunction

    // Next tick in the running time base, sticks random
    task automatic offer(input logic [4:0] sw, input logic home, input logic tog);
        if ($urandom_range(0, 3) != 0)
            clock_ms = clock_ms + $urandom_range(1, 25);
        direct(clock_ms, sw, pick_stick(), pick_stick(), home, tog);
    endtask

    // Well-formed homing: press, edge search, reversal, centre search
    task automatic homing_run(input bit late);
        int         edge_wait;
        int         centre_wait;
        int         hold;
        int         n;
        int         jump_at;
        logic [4:0] sw;
        edge_wait   = $urandom_range(0, 10);
        centre_wait = $urandom_range(0, 10);
        hold        = $urandom_range(1, 4);
        n           = edge_wait + centre_wait + 2;
        jump_at     = $urandom_range(0, n - 1);
        // button released first so the press is a rising edge
        offer(rand_switches(15) & 5'b00011, 1'b0, tog_level);
        for (int k = 0; k < n; k++) begin
            sw = rand_switches(15) & 5'b00011;
            if (k < edge_wait) begin
                sw[2] = ($urandom_range(0, 4) == 0);
            end else if (k == edge_wait) begin
                case ($urandom_range(0, 2))
                    0: sw[4] = 1'b1;
                    1: sw[3] = 1'b1;
                    default: sw[4:3] = 2'b11;
                endcase
            end else begin
                sw[4:3] = 2'($urandom_range(0, 3));
                sw[2]   = (k == n - 1);
            end
            if (late && k == jump_at)
                clock_ms = clock_ms + cur_timeout;
            if ($urandom_range(0, 4) == 0)
                tog_level = ~tog_level;
            offer(sw, k < hold, tog_level);
        end
    endtask

    // Jogging with the odd home press dropped in
    task automatic jog_run(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 2) == 0)
                tog_level = ~tog_level;
            offer(rand_switches(20), $urandom_range(0, 24) == 0, tog_level);
        end
    endtask

    task automatic noise_run(input int n);
        for (int k = 0; k < n; k++)
            direct($urandom, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (results_owed != 0) @(negedge clk);
    endtask

    // Main stimulus
    initial begin : stimulus
        int base;
        int dz;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_valid          = 1'b0;
        now_ms            = '0;
        pan_left_limit    = 1'b0;
        pan_right_limit   = 1'b0;
        pan_center_switch = 1'b0;
        tilt_up_limit     = 1'b0;
        tilt_down_limit   = 1'b0;
        pan_stick         = '0;
        tilt_stick        = '0;
        home_button       = 1'b0;
        toggle_button     = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed ticks at reset settings (deadzone 20, timeout 30000)
        direct(32'h0000_0000, 5'b00000, 8'h80, 8'h7F, 1'b0, 1'b1);
        // toggle release while not homed: edge swallowed
        direct(32'hFFFF_FFFF, 5'b00000, 8'h7F, 8'h80, 1'b0, 1'b0);
        // home press with both edges closed: A wins
        direct(32'd10, 5'b11111, 8'h00, 8'h00, 1'b1, 1'b0);
        direct(32'd11, 5'b11011, 8'h00, 8'h00, 1'b1, 1'b0);
        direct(32'd12, 5'b00000, 8'h00, 8'h00, 1'b0, 1'b0);
        // press while busy is ignored
        direct(32'd13, 5'b00000, 8'h00, 8'h00, 1'b1, 1'b1);
        direct(32'd14, 5'b00100, 8'h80, 8'h7F, 1'b1, 1'b0);
        // complete phase, then back to idle and jogging on the same tick
        direct(32'd15, 5'b00000, 8'h80, 8'h7F, 1'b1, 1'b0);
        direct(32'd16, 5'b00000, 8'h7F, 8'h80, 1'b0, 1'b0);
        // wanted side blocked by its switch
        direct(32'd17, 5'b10010, 8'h80, 8'h80, 1'b0, 1'b0);
        direct(32'd18, 5'b01001, 8'h7F, 8'h7F, 1'b0, 1'b0);
        direct(32'd19, 5'b10010, 8'h7F, 8'h7F, 1'b0, 1'b0);
        // exactly at the deadzone, then one beyond
        direct(32'd20, 5'b00000, 8'h14, 8'hEC, 1'b0, 1'b0);
        direct(32'd21, 5'b00000, 8'hEB, 8'h15, 1'b0, 1'b1);
        direct(32'd22, 5'b00000, 8'h00, 8'h00, 1'b0, 1'b0);
        // homing from switch B, elapsed equal to the limit, then past it
        direct(32'd100, 5'b01000, 8'h00, 8'h00, 1'b1, 1'b0);
        direct(32'd30100, 5'b00000, 8'h00, 8'h00, 1'b1, 1'b0);
        direct(32'd30101, 5'b00000, 8'h00, 8'h00, 1'b0, 1'b0);
        // homing across the timestamp wrap
        direct(32'hFFFF_FFF0, 5'b00000, 8'h00, 8'h00, 1'b1, 1'b0);
        direct(32'h0000_0010, 5'b10000, 8'h00, 8'h00, 1'b1, 1'b0);
        direct(32'h0000_0020, 5'b00100, 8'h00, 8'h00, 1'b0, 1'b0);
        direct(32'h0000_0021, 5'b11111, 8'h80, 8'h80, 1'b0, 1'b0);
        direct(32'h0000_0022, 5'b00000, 8'h55, 8'hAA, 1'b0, 1'b0);
        clock_ms = 32'h0000_0100;

        // random phases, each with its own settings and idling pattern
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: begin dz = 0;   cur_timeout = 32'd0;          end
                    2: begin dz = 127; cur_timeout = 32'hFFFF_FFFF;  end
                    3: begin dz = $urandom_range(0, 127);
                             cur_timeout = $urandom_range(30, 300);  end
                    4: begin dz = 1;   cur_timeout = 32'd60;         end
                    5: begin dz = 126; cur_timeout = 32'd30000;      end
                    6: begin dz = $urandom_range(0, 127);
                             cur_timeout = 32'd150;
                             clock_ms = 32'hFFFF_F000;               end
                    default: begin dz = 20; cur_timeout = $urandom; end
                endcase
                cur_deadzone = dz;
                // upper data bits are junk for the 7-bit register
                write_reg(CFG_DEADZONE, {25'($urandom), 7'(dz)});
                write_reg(CFG_HOMING_TIMEOUT, cur_timeout);
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            // long hold-off on the result side while items keep coming
            if (ph == 0 || ph == 4)
                stall_burst = 120;
            base = sent_items;
            while (sent_items - base < 55) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        homing_run(1'b0);
                        jog_run($urandom_range(4, 16));
                    end
                    5, 6: begin
                        homing_run(1'b1);
                        jog_run($urandom_range(3, 8));
                    end
                    7, 8: jog_run($urandom_range(5, 15));
                    default: noise_run($urandom_range(3, 8));
                endcase
            end
        end

        drain();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && results_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/thjc_pkg.sv
rtl/core/thjc_step.sv
rtl/core/two_axis_homing_and_jog_controller.sv
rtl/core/thjc_checker.sv
dv/thjc_tick_checker.sv
dv/tb_two_axis_homing_and_jog_controller.sv
